### src/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope shaper package
// Shared widths, register indexes, phase codes and the controller command.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

	localparam int LEN_W     = 24;
	localparam int SAMPLE_W  = 16;
	localparam int Q15_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = 16;
	localparam int PROD_W    = Q15_W + LEN_W;

	localparam logic [Q15_W-1:0] UNITY_Q15   = 16'h8000;
	localparam logic [LEN_W-1:0] TOTAL_RESET = 24'd132300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_TOTAL   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_ATTACK,
		PH_DECAY,
		PH_RELEASE,
		PH_ZERO,
		PH_SUSTAIN
	} phase_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

### src/adsr_in_if.sv
// ----------------------------------------------------------------------------
// ADSR input sample channel
// Valid/ready channel carrying one signed audio sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if;
	import adsr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### src/adsr_out_if.sv
// ----------------------------------------------------------------------------
// ADSR output sample channel
// Valid/ready channel carrying one shaped sample and its note end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_out_if;
	import adsr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       note_end;

	modport source (output valid, output sample_out, output note_end, input ready);
	modport sink (input valid, input sample_out, input note_end, output ready);
endinterface

`default_nettype wire

### src/adsr_cfg_if.sv
// ----------------------------------------------------------------------------
// ADSR configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_cfg_if;
	import adsr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEN_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/adsr_envelope_shaper_core.sv
// ----------------------------------------------------------------------------
// ADSR envelope shaper core
// Multiplies each audio sample by a linear attack/decay/sustain/release gain.
// ----------------------------------------------------------------------------
// Samples are taken one at a time: an accepted input beat passes through the
// multiply, the 16-step restoring divider and a done state that waits for room
// in the output register. An output beat waiting in the output register does not
// block the next input. Reset (arst_n, asynchronous, active low) clears the
// sample counter and the control state and loads the registers with their defaults; no clearing pass.
`default_nettype none

module adsr_envelope_shaper_core #(
	parameter int COUNT_BITS = 24
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	adsr_cfg_if.sink     cfg,
	adsr_in_if.sink      din,
	adsr_out_if.source   dout
);
	import adsr_pkg::*;

	// Envelope registers. Writes to an index beyond the register list are
	// accepted and dropped. The configuration channel never stalls.
	logic [LEN_W-1:0] attack_len_q;
	logic [LEN_W-1:0] decay_len_q;
	logic [Q15_W-1:0] sustain_level_q;
	logic [LEN_W-1:0] release_len_q;
	logic [LEN_W-1:0] total_len_q;

	ctrl_cmd_t cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q    <= '0;
			decay_len_q     <= '0;
			sustain_level_q <= UNITY_Q15;
			release_len_q   <= '0;
			total_len_q     <= TOTAL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ATTACK:  attack_len_q    <= cfg.data;
				REG_DECAY:   decay_len_q     <= cfg.data;
				REG_SUSTAIN: sustain_level_q <= cfg.data[Q15_W-1:0];
				REG_RELEASE: release_len_q   <= cfg.data;
				REG_TOTAL:   total_len_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// The controller walks each sample through capture, the multiply state,
	// sixteen division steps and the final rounding into the output register.
	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	// The datapath holds the sample counter, the phase decision, the divider
	// and the output payload register.
	adsr_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.attack_len    (attack_len_q),
		.decay_len     (decay_len_q),
		.sustain_level (sustain_level_q),
		.release_len   (release_len_q),
		.total_len     (total_len_q),
		.sample_in     (din.sample_in),
		.sample_out    (dout.sample_out),
		.note_end      (dout.note_end)
	);
endmodule

`default_nettype wire

### src/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// ADSR controller
// Sequences capture, scaling multiply, division steps and output loading.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output adsr_pkg::ctrl_cmd_t      cmd
);
	import adsr_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   step_q;
	logic               out_valid_q;
	logic               can_load;

	// The output register may be refilled when empty or when its beat leaves now.
	assign can_load = !out_valid_q || out_ready;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.load     = in_valid && (state_q == ST_IDLE);
	assign cmd.mul      = (state_q == ST_MUL);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.finish   = (state_q == ST_DONE) && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

### src/adsr_dp.sv
// ----------------------------------------------------------------------------
// ADSR datapath
// Phase select, scaling multiply, restoring divider and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_dp #(
	parameter int COUNT_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire adsr_pkg::ctrl_cmd_t                   cmd,
	input  wire logic [adsr_pkg::LEN_W-1:0]            attack_len,
	input  wire logic [adsr_pkg::LEN_W-1:0]            decay_len,
	input  wire logic [adsr_pkg::Q15_W-1:0]            sustain_level,
	input  wire logic [adsr_pkg::LEN_W-1:0]            release_len,
	input  wire logic [adsr_pkg::LEN_W-1:0]            total_len,
	input  wire logic signed [adsr_pkg::SAMPLE_W-1:0]  sample_in,
	output logic signed [adsr_pkg::SAMPLE_W-1:0]       sample_out,
	output logic                                       note_end
);
	import adsr_pkg::*;

	// Wide enough for the index, for attack plus decay, and for the index plus one.
	localparam int EW = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 2;

	logic [COUNT_BITS-1:0]      idx_q;
	logic [COUNT_BITS:0]        idx_inc;
	logic [EW-1:0]              idx_e, att_e, dec_e, rel_e, tot_e, ad_e;
	logic                       last;
	logic [Q15_W-1:0]           s_sat;

	phase_t                     phase_d, phase_q;
	logic [Q15_W-1:0]           mul_d, mul_q;
	logic [LEN_W-1:0]           opd_d, opd_q;
	logic [LEN_W-1:0]           div_d, div_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       note_end_q;

	logic [PROD_W-1:0]          prod;
	logic [LEN_W-1:0]           rem_q;
	logic [Q15_W-1:0]           quo_q;
	logic [LEN_W:0]             trial, diff;
	logic                       fits;

	logic [Q15_W-1:0]           env;
	logic signed [2*SAMPLE_W:0] scaled, rounded;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	assign idx_e = EW'(idx_q);
	assign att_e = EW'(attack_len);
	assign dec_e = EW'(decay_len);
	assign rel_e = EW'(release_len);
	assign tot_e = EW'(total_len);
	assign ad_e  = att_e + dec_e;
	assign s_sat = (sustain_level > UNITY_Q15) ? UNITY_Q15 : sustain_level;

	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign last    = EW'(idx_inc) >= tot_e;

	// Each ramp is factor * operand / divisor with a quotient below 2^16.
	always_comb begin
		phase_d = PH_SUSTAIN;
		mul_d   = UNITY_Q15;
		opd_d   = LEN_W'(idx_e);
		div_d   = attack_len;
		priority if (idx_e < att_e) begin
			phase_d = PH_ATTACK;
		end else if (idx_e < ad_e) begin
			phase_d = PH_DECAY;
			mul_d   = UNITY_Q15 - s_sat;
			opd_d   = LEN_W'(idx_e - att_e);
			div_d   = decay_len;
		end else if ((release_len <= total_len) && (idx_e >= tot_e - rel_e)) begin
			if ((idx_e >= tot_e) || (release_len == '0)) begin
				phase_d = PH_ZERO;
			end else begin
				phase_d = PH_RELEASE;
				mul_d   = s_sat;
				opd_d   = LEN_W'(tot_e - idx_e);
				div_d   = release_len;
			end
		end else begin
			phase_d = PH_SUSTAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= last ? '0 : idx_inc[COUNT_BITS-1:0];
		end
	end

	assign prod  = mul_q * opd_q;
	assign trial = {rem_q, quo_q[Q15_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_comb begin
		unique case (phase_q)
			PH_ATTACK:  env = quo_q;
			PH_DECAY:   env = UNITY_Q15 - quo_q;
			PH_RELEASE: env = quo_q;
			PH_ZERO:    env = '0;
			PH_SUSTAIN: env = s_sat;
			default:    env = s_sat;
		endcase
	end

	assign scaled  = sample_q * $signed({1'b0, env});
	assign rounded = scaled + (2*SAMPLE_W+1)'(16384);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			phase_q    <= phase_d;
			mul_q      <= mul_d;
			opd_q      <= opd_d;
			div_q      <= div_d;
			sample_q   <= sample_in;
			note_end_q <= last;
		end
		if (cmd.mul) begin
			rem_q <= prod[PROD_W-1:Q15_W];
			quo_q <= prod[Q15_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			quo_q <= {quo_q[Q15_W-2:0], fits};
		end
		if (cmd.finish) begin
			sample_out_q <= rounded[SAMPLE_W+14:15];
			note_end     <= note_end_q;
		end
	end

	assign sample_out = sample_out_q;
endmodule

`default_nettype wire
